>>> sv/fcdma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcdma_pkg: shared types and codes of the four-channel DMA controller
// Word layouts of both channels, operation codes, register offsets and
// mode bit positions.
// ----------------------------------------------------------------------------
package fcdma_pkg;

    // Operation codes carried in the func field
    localparam logic [2:0] FUNC_REG_WR   = 3'd0;
    localparam logic [2:0] FUNC_REG_RD   = 3'd1;
    localparam logic [2:0] FUNC_REQ_LINE = 3'd2;
    localparam logic [2:0] FUNC_BANK_WR  = 3'd3;
    localparam logic [2:0] FUNC_CMASK_WR = 3'd4;
    localparam logic [2:0] FUNC_BANK_RD  = 3'd5;
    localparam logic [2:0] FUNC_CMASK_RD = 3'd6;
    localparam logic [2:0] FUNC_TICK     = 3'd7;

    // Programming register offsets above the address/count block
    localparam logic [3:0] REG_COMMAND   = 4'd8;
    localparam logic [3:0] REG_STATUS    = 4'd8;
    localparam logic [3:0] REG_REQUEST   = 4'd9;
    localparam logic [3:0] REG_SMASK     = 4'd10;
    localparam logic [3:0] REG_MODE      = 4'd11;
    localparam logic [3:0] REG_CLR_FF    = 4'd12;
    localparam logic [3:0] REG_MASTER    = 4'd13;
    localparam logic [3:0] REG_TEMP      = 4'd13;
    localparam logic [3:0] REG_CLR_MASK  = 4'd14;

    // Transfer kinds from mode bits 3:2
    localparam logic [1:0] KIND_VERIFY   = 2'd0;
    localparam logic [1:0] KIND_IO2MEM   = 2'd1;
    localparam logic [1:0] KIND_MEM2IO   = 2'd2;
    localparam logic [1:0] KIND_ILLEGAL  = 2'd3;

    // Terminal count line events
    localparam logic [1:0] TC_NONE       = 2'd0;
    localparam logic [1:0] TC_ASSERT     = 2'd1;
    localparam logic [1:0] TC_CLEARED    = 2'd2;

    // Mode bit positions
    localparam int MODE_AUTO_BIT = 4;
    localparam int MODE_DEC_BIT  = 5;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WORD_MODE = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ADDR_MASK = 1'd1;

    localparam logic [31:0] ADDR_MASK_RESET = 32'h00FF_FFFF;
    localparam logic [7:0]  READ_UNMAPPED   = 8'hFF;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  reg_addr;
        logic [7:0]  write_value;
        logic [7:0]  write_mask;
        logic [1:0]  channel;
        logic [15:0] transfer_data;
    } dma_in_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        xfer_valid;
        logic [1:0]  xfer_channel;
        logic [1:0]  xfer_kind;
        logic [31:0] mem_address;
        logic [1:0]  tc_line_event;
    } dma_out_t;

endpackage

>>> sv/fcdma_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcdma_core: controller state and single-pass operation logic
// Holds all channel and global registers; on each fire the registered word
// is decoded, the state is updated and the result word is formed.
// ----------------------------------------------------------------------------
module fcdma_core #(
    parameter int BANK_WIDTH = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  fcdma_pkg::dma_in_t  item,
    input  logic                word_mode,
    input  logic [31:0]         address_mask,
    output fcdma_pkg::dma_out_t result
);
    import fcdma_pkg::*;

    logic                  ff_reg, ff_next;
    logic [7:0]            command_reg, command_next;
    logic [3:0]            request_reg, request_next;
    logic [3:0]            mask_reg, mask_next;
    logic [3:0]            tc_reg, tc_next;
    logic [15:0]           temp_reg, temp_next;
    logic [15:0]           base_addr_reg [4];
    logic [15:0]           base_addr_next [4];
    logic [15:0]           cur_addr_reg [4];
    logic [15:0]           cur_addr_next [4];
    logic [15:0]           base_cnt_reg [4];
    logic [15:0]           base_cnt_next [4];
    logic [15:0]           cur_cnt_reg [4];
    logic [15:0]           cur_cnt_next [4];
    logic [7:0]            mode_reg [4];
    logic [7:0]            mode_next [4];
    logic [BANK_WIDTH-1:0] bank_reg [4];
    logic [BANK_WIDTH-1:0] bank_next [4];
    logic [BANK_WIDTH-1:0] cmask_reg [4];
    logic [BANK_WIDTH-1:0] cmask_next [4];

    logic [3:0]            pending;
    logic                  serve_hit;
    logic [1:0]            serve_ch;
    logic [1:0]            sel_ch;

    // Pick the lowest-numbered requested, unmasked channel
    always_comb begin
        pending   = request_reg & ~mask_reg;
        serve_hit = |pending;
        if (pending[0]) begin
            serve_ch = 2'd0;
        end else if (pending[1]) begin
            serve_ch = 2'd1;
        end else if (pending[2]) begin
            serve_ch = 2'd2;
        end else begin
            serve_ch = 2'd3;
        end
    end

    // Word's channel: served on tick, reg_addr on register access, else channel
    always_comb begin
        if (item.func == FUNC_TICK) begin
            sel_ch = serve_ch;
        end else if (item.func == FUNC_REG_WR || item.func == FUNC_REG_RD) begin
            sel_ch = item.reg_addr[2:1];
        end else begin
            sel_ch = item.channel;
        end
    end

    logic [15:0]           sel_base_a, sel_cur_a, sel_base_c, sel_cur_c;
    logic [7:0]            sel_mode;
    logic [BANK_WIDTH-1:0] sel_bank, sel_cmask;
    logic [BANK_WIDTH-1:0] wv_b, wm_b, bank_step;
    logic [15:0]           old_base, loaded, rd_word, addr_step;
    logic [3:0]            op_bit, ch_bit;
    logic [31:0]           full_addr, shift_addr;
    logic                  dec, wrap;

    // Decode and execute the word
    always_comb begin
        ff_next        = ff_reg;
        command_next   = command_reg;
        request_next   = request_reg;
        mask_next      = mask_reg;
        tc_next        = tc_reg;
        temp_next      = temp_reg;
        base_addr_next = base_addr_reg;
        cur_addr_next  = cur_addr_reg;
        base_cnt_next  = base_cnt_reg;
        cur_cnt_next   = cur_cnt_reg;
        mode_next      = mode_reg;
        bank_next      = bank_reg;
        cmask_next     = cmask_reg;
        result         = '0;

        sel_base_a = base_addr_reg[sel_ch];
        sel_cur_a  = cur_addr_reg[sel_ch];
        sel_base_c = base_cnt_reg[sel_ch];
        sel_cur_c  = cur_cnt_reg[sel_ch];
        sel_mode   = mode_reg[sel_ch];
        sel_bank   = bank_reg[sel_ch];
        sel_cmask  = cmask_reg[sel_ch];

        wv_b   = BANK_WIDTH'(item.write_value);
        wm_b   = BANK_WIDTH'(item.write_mask);
        op_bit = 4'b0001 << item.write_value[1:0];
        ch_bit = 4'b0001 << sel_ch;

        old_base = item.reg_addr[0] ? sel_base_c : sel_base_a;
        loaded   = ff_reg ? {item.write_value, old_base[7:0]}
                          : {old_base[15:8], item.write_value};
        rd_word  = item.reg_addr[0] ? sel_cur_c : sel_cur_a;

        dec       = sel_mode[MODE_DEC_BIT];
        addr_step = dec ? sel_cur_a - 16'd1 : sel_cur_a + 16'd1;
        wrap      = dec ? (sel_cur_a == 16'h0000) : (sel_cur_a == 16'hFFFF);
        bank_step = dec ? sel_bank - BANK_WIDTH'(1) : sel_bank + BANK_WIDTH'(1);
        full_addr  = {16'(sel_bank), sel_cur_a};
        shift_addr = word_mode ? {full_addr[30:0], 1'b0} : full_addr;

        if (fire) begin
            case (item.func)
                FUNC_REG_WR: begin
                    if (!item.reg_addr[3]) begin
                        // load a byte of base and copy into current
                        if (!item.reg_addr[0]) begin
                            base_addr_next[sel_ch] = loaded;
                            cur_addr_next[sel_ch]  = loaded;
                        end else begin
                            base_cnt_next[sel_ch] = loaded;
                            cur_cnt_next[sel_ch]  = loaded;
                        end
                        ff_next = ~ff_reg;
                    end else begin
                        case (item.reg_addr)
                            REG_COMMAND: command_next = item.write_value;
                            REG_REQUEST: begin
                                request_next = item.write_value[2] ? request_reg | op_bit
                                                                   : request_reg & ~op_bit;
                            end
                            REG_SMASK: begin
                                mask_next = item.write_value[2] ? mask_reg | op_bit
                                                                : mask_reg & ~op_bit;
                            end
                            REG_MODE: mode_next[item.write_value[1:0]] = item.write_value;
                            REG_CLR_FF: ff_next = 1'b0;
                            REG_MASTER: begin
                                ff_next      = 1'b0;
                                command_next = '0;
                                request_next = '0;
                                tc_next      = '0;
                                mask_next    = 4'hF;
                            end
                            REG_CLR_MASK: mask_next = '0;
                            default: mask_next = item.write_value[3:0];
                        endcase
                    end
                end
                FUNC_REG_RD: begin
                    if (!item.reg_addr[3]) begin
                        result.read_data = ff_reg ? rd_word[15:8] : rd_word[7:0];
                        ff_next = ~ff_reg;
                    end else if (item.reg_addr == REG_STATUS) begin
                        result.read_data = {request_reg, tc_reg};
                        tc_next = '0;
                    end else if (item.reg_addr == REG_TEMP) begin
                        result.read_data = temp_reg[7:0];
                    end else begin
                        result.read_data = READ_UNMAPPED;
                    end
                end
                FUNC_REQ_LINE: begin
                    if (item.write_value[0]) begin
                        if (!request_reg[sel_ch]) begin
                            request_next = request_reg | ch_bit;
                            result.tc_line_event = TC_CLEARED;
                        end
                    end else begin
                        request_next = request_reg & ~ch_bit;
                    end
                end
                FUNC_BANK_WR: bank_next[sel_ch] = (sel_bank & ~wm_b) | (wv_b & wm_b);
                FUNC_CMASK_WR: cmask_next[sel_ch] = (sel_cmask & ~wm_b) | (wv_b & wm_b);
                FUNC_BANK_RD: result.read_data = 8'(sel_bank);
                FUNC_CMASK_RD: result.read_data = 8'(sel_cmask);
                default: begin
                    if (serve_hit) begin
                        // report the transfer
                        result.xfer_valid   = 1'b1;
                        result.xfer_channel = sel_ch;
                        result.xfer_kind    = sel_mode[3:2];
                        result.mem_address  = shift_addr & address_mask;
                        if (sel_mode[3:2] != KIND_ILLEGAL) begin
                            temp_next = item.transfer_data;
                        end
                        // step address, carry into the masked bank bits
                        cur_addr_next[sel_ch] = addr_step;
                        if (wrap) begin
                            bank_next[sel_ch] = (sel_bank & ~sel_cmask)
                                              | (bank_step & sel_cmask);
                        end
                        // count down, terminal count on underflow
                        if (sel_cur_c == 16'h0000) begin
                            if (sel_mode[MODE_AUTO_BIT]) begin
                                cur_addr_next[sel_ch] = sel_base_a;
                                cur_cnt_next[sel_ch]  = sel_base_c;
                            end else begin
                                cur_cnt_next[sel_ch] = 16'hFFFF;
                                mask_next = mask_reg | ch_bit;
                            end
                            request_next = request_reg & ~ch_bit;
                            tc_next      = tc_reg | ch_bit;
                            result.tc_line_event = TC_ASSERT;
                        end else begin
                            cur_cnt_next[sel_ch] = sel_cur_c - 16'd1;
                        end
                    end
                end
            endcase
        end
    end

    // Commit state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ff_reg      <= 1'b0;
            command_reg <= '0;
            request_reg <= '0;
            mask_reg    <= 4'hF;
            tc_reg      <= '0;
            temp_reg    <= '0;
            for (int i = 0; i < 4; i++) begin
                base_addr_reg[i] <= '0;
                cur_addr_reg[i]  <= '0;
                base_cnt_reg[i]  <= '0;
                cur_cnt_reg[i]   <= '0;
                mode_reg[i]      <= '0;
                bank_reg[i]      <= '0;
                cmask_reg[i]     <= '0;
            end
        end else begin
            ff_reg        <= ff_next;
            command_reg   <= command_next;
            request_reg   <= request_next;
            mask_reg      <= mask_next;
            tc_reg        <= tc_next;
            temp_reg      <= temp_next;
            base_addr_reg <= base_addr_next;
            cur_addr_reg  <= cur_addr_next;
            base_cnt_reg  <= base_cnt_next;
            cur_cnt_reg   <= cur_cnt_next;
            mode_reg      <= mode_next;
            bank_reg      <= bank_next;
            cmask_reg     <= cmask_next;
        end
    end

endmodule

>>> sv/four_channel_dma_controller.sv
`timescale 1ns / 1ps
// Path: a word accepted into the input register is decoded by the core once the
// result register is free or being taken; its result word is then held there.
// Throughput: one word per cycle unless m_ready stalls it; the input register, the
// single-pass core and the result register each take one word per cycle.
// Reset (aresetn low, synchronous): all channels masked, every other register
// zero, address mask back to 24 bits, both pipeline registers empty.
// ----------------------------------------------------------------------------
// four_channel_dma_controller: top level
// Input register, configuration registers, core and result register.
// ----------------------------------------------------------------------------
module four_channel_dma_controller #(
    parameter int BANK_WIDTH = 8
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  fcdma_pkg::dma_in_t                        s_data,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output fcdma_pkg::dma_out_t                       m_data,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [fcdma_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [31:0]                               cfg_data
);
    import fcdma_pkg::*;

    logic        word_mode_reg;
    logic [31:0] mem_mask_reg;
    logic        in_valid_reg;
    dma_in_t     in_item_reg;
    logic        out_valid_reg;
    dma_out_t    out_item_reg;
    logic        fire;
    dma_out_t    result;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || fire;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_item_reg;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_mode_reg <= 1'b0;
            mem_mask_reg  <= ADDR_MASK_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WORD_MODE: word_mode_reg <= cfg_data[0];
                CFG_ADDR_MASK: mem_mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    fcdma_core #(
        .BANK_WIDTH (BANK_WIDTH)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .item         (in_item_reg),
        .word_mode    (word_mode_reg),
        .address_mask (mem_mask_reg),
        .result       (result)
    );

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_item_reg <= result;
        end
    end

endmodule

>>> sim/four_channel_dma_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_channel_dma_controller_test: self-checking bench for the DMA controller
// Drives operation words through the input channel and configuration writes
// between phases. A behavioral copy of the controller state predicts each
// result word, and every word returned on the result channel is compared
// field by field against the oldest prediction. Random idle gaps on both sides.
// ----------------------------------------------------------------------------
module four_channel_dma_controller_test;
    import fcdma_pkg::*;

    // Offset 15 loads all four mask bits; the package has no name for it
    localparam logic [3:0] REG_LOAD_MASK = 4'd15;
    localparam int         MAX_REPORTS   = 40;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    dma_in_t                    s_data = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    dma_out_t                   m_data;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [31:0]                cfg_data = '0;

    // Controller state as predicted by the bench
    logic        word_mode;
    logic [31:0] mem_mask;
    logic        flip_hi;
    logic [3:0]  req_bits;
    logic [3:0]  mask_bits;
    logic [3:0]  tc_bits;
    logic [15:0] temp_reg;
    logic [15:0] base_addr [4];
    logic [15:0] cur_addr [4];
    logic [15:0] base_cnt [4];
    logic [15:0] cur_cnt [4];
    logic [7:0]  chan_mode [4];
    logic [7:0]  bank [4];
    logic [7:0]  carry_mask [4];

    dma_out_t    dma_results_due[$];
    dma_out_t    oldest_due;
    int unsigned error_count = 0;
    int unsigned words_sent = 0;
    bit          no_idle = 1'b0;
    int unsigned ready_hold = 0;
    int unsigned ready_gap;

    four_channel_dma_controller u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Idle length: mostly none, some short, a few long
    function automatic int unsigned idle_gap();
        int unsigned roll;
        if (no_idle) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] load_byte(input logic [15:0] old, input logic [7:0] v);
        return flip_hi ? {v, old[7:0]} : {old[15:8], v};
    endfunction

    // Apply one operation word to the predicted state and return its result word
    function automatic dma_out_t dma_result_of(input dma_in_t w);
        dma_out_t    r;
        logic [3:0]  sel;
        logic [3:0]  tick_bit;
        logic [1:0]  rch;
        logic [1:0]  ch;
        logic [15:0] val;
        logic [31:0] addr;
        logic [7:0]  mode;
        logic [7:0]  cm;
        logic        found;
        int          i;
        r = '0;
        sel = 4'b0001 << w.channel;
        rch = w.reg_addr[2:1];
        case (w.func)
            FUNC_REG_WR: begin
                if (!w.reg_addr[3]) begin
                    if (!w.reg_addr[0]) begin
                        base_addr[rch] = load_byte(base_addr[rch], w.write_value);
                        cur_addr[rch] = base_addr[rch];
                    end else begin
                        base_cnt[rch] = load_byte(base_cnt[rch], w.write_value);
                        cur_cnt[rch] = base_cnt[rch];
                    end
                    flip_hi = ~flip_hi;
                end else begin
                    tick_bit = 4'b0001 << w.write_value[1:0];
                    case (w.reg_addr)
                        REG_COMMAND: ;
                        REG_REQUEST: begin
                            if (w.write_value[2]) req_bits |= tick_bit;
                            else req_bits &= ~tick_bit;
                        end
                        REG_SMASK: begin
                            if (w.write_value[2]) mask_bits |= tick_bit;
                            else mask_bits &= ~tick_bit;
                        end
                        REG_MODE: chan_mode[w.write_value[1:0]] = w.write_value;
                        REG_CLR_FF: flip_hi = 1'b0;
                        REG_MASTER: begin
                            flip_hi = 1'b0;
                            req_bits = '0;
                            tc_bits = '0;
                            mask_bits = 4'hF;
                        end
                        REG_CLR_MASK: mask_bits = '0;
                        default: mask_bits = w.write_value[3:0];
                    endcase
                end
            end
            FUNC_REG_RD: begin
                if (!w.reg_addr[3]) begin
                    val = w.reg_addr[0] ? cur_cnt[rch] : cur_addr[rch];
                    r.read_data = flip_hi ? val[15:8] : val[7:0];
                    flip_hi = ~flip_hi;
                end else if (w.reg_addr == REG_STATUS) begin
                    r.read_data = {req_bits, tc_bits};
                    tc_bits = '0;
                end else if (w.reg_addr == REG_TEMP) begin
                    r.read_data = temp_reg[7:0];
                end else begin
                    r.read_data = READ_UNMAPPED;
                end
            end
            FUNC_REQ_LINE: begin
                if (w.write_value[0]) begin
                    if ((req_bits & sel) == '0) begin
                        req_bits |= sel;
                        r.tc_line_event = TC_CLEARED;
                    end
                end else begin
                    req_bits &= ~sel;
                end
            end
            FUNC_BANK_WR: begin
                bank[w.channel] = (bank[w.channel] & ~w.write_mask)
                                | (w.write_value & w.write_mask);
            end
            FUNC_CMASK_WR: begin
                carry_mask[w.channel] = (carry_mask[w.channel] & ~w.write_mask)
                                      | (w.write_value & w.write_mask);
            end
            FUNC_BANK_RD: r.read_data = bank[w.channel];
            FUNC_CMASK_RD: r.read_data = carry_mask[w.channel];
            default: begin
                // Serve the lowest requested, unmasked channel
                found = 1'b0;
                ch = 2'd0;
                for (i = 3; i >= 0; i--) begin
                    if (req_bits[i] && !mask_bits[i]) begin
                        ch = 2'(i);
                        found = 1'b1;
                    end
                end
                if (found) begin
                    mode = chan_mode[ch];
                    tick_bit = 4'b0001 << ch;
                    cm = carry_mask[ch];
                    if (mode[3:2] != KIND_ILLEGAL) temp_reg = w.transfer_data;
                    addr = {8'h00, bank[ch], cur_addr[ch]};
                    if (word_mode) addr = addr << 1;
                    r.xfer_valid = 1'b1;
                    r.xfer_channel = ch;
                    r.xfer_kind = mode[3:2];
                    r.mem_address = addr & mem_mask;
                    // Step the address, carrying into the bank bits the mask selects
                    if (mode[MODE_DEC_BIT]) begin
                        cur_addr[ch] = cur_addr[ch] - 16'd1;
                        if (cur_addr[ch] == 16'hFFFF) begin
                            bank[ch] = (bank[ch] & ~cm) | ((bank[ch] - 8'd1) & cm);
                        end
                    end else begin
                        cur_addr[ch] = cur_addr[ch] + 16'd1;
                        if (cur_addr[ch] == 16'h0000) begin
                            bank[ch] = (bank[ch] & ~cm) | ((bank[ch] + 8'd1) & cm);
                        end
                    end
                    // Terminal count on underflow: reload or mask
                    if (cur_cnt[ch] == 16'h0000) begin
                        cur_cnt[ch] = 16'hFFFF;
                        if (mode[MODE_AUTO_BIT]) begin
                            cur_addr[ch] = base_addr[ch];
                            cur_cnt[ch] = base_cnt[ch];
                        end else begin
                            mask_bits |= tick_bit;
                        end
                        req_bits &= ~tick_bit;
                        tc_bits |= tick_bit;
                        r.tc_line_event = TC_ASSERT;
                    end else begin
                        cur_cnt[ch] = cur_cnt[ch] - 16'd1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic dma_in_t dma_word(input logic [2:0] func, input logic [3:0] reg_addr,
                                         input logic [7:0] value, input logic [7:0] wmask,
                                         input logic [1:0] ch, input logic [15:0] data);
        dma_in_t w;
        w.func = func;
        w.reg_addr = reg_addr;
        w.write_value = value;
        w.write_mask = wmask;
        w.channel = ch;
        w.transfer_data = data;
        return w;
    endfunction

    function automatic dma_in_t random_word();
        return dma_word(3'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
                        2'($urandom), 16'($urandom));
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_REPORTS) $display("mismatch: %s", msg);
        error_count++;
    endtask

    // Send one word; predict its result at the accepting edge
    task automatic send_word(input dma_in_t w);
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        dma_results_due.push_back(dma_result_of(w));
        words_sent++;
    endtask

    // Write a configuration register once the controller has drained
    task automatic write_cfg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [31:0] value);
        s_valid <= 1'b0;
        while (dma_results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_WORD_MODE) word_mode = value[0];
        else mem_mask = value;
    endtask

    // Register map, bank registers and one transfer across a bank carry
    task automatic test_register_access();
        send_word(dma_word(FUNC_REG_RD, REG_STATUS, 8'h00, 8'h00, 2'd0, 16'h0000));
        send_word(dma_word(FUNC_REG_WR, 4'd0, 8'hFF, 8'h00, 2'd0, 16'h0000));
        send_word(dma_word(FUNC_REG_WR, 4'd0, 8'hFF, 8'h00, 2'd0, 16'h0000));
        send_word(dma_word(FUNC_REG_RD, 4'd1, 8'h00, 8'h00, 2'd0, 16'h0000));
        send_word(dma_word(FUNC_REG_RD, REG_LOAD_MASK, 8'h00, 8'h00, 2'd0, 16'h0000));
        send_word(dma_word(FUNC_BANK_WR, 4'd0, 8'hFF, 8'h0F, 2'd0, 16'h0000));
        send_word(dma_word(FUNC_CMASK_WR, 4'd0, 8'hFF, 8'hFF, 2'd0, 16'h0000));
        send_word(dma_word(FUNC_REG_WR, REG_MODE, 8'h04, 8'h00, 2'd0, 16'h0000));
        // Nothing to serve: every channel still masked
        send_word(dma_word(FUNC_TICK, 4'd0, 8'h00, 8'h00, 2'd0, 16'h1234));
        send_word(dma_word(FUNC_REG_WR, REG_SMASK, 8'h00, 8'h00, 2'd0, 16'h0000));
        // Rising request, then the same level again
        send_word(dma_word(FUNC_REQ_LINE, 4'd0, 8'h01, 8'h00, 2'd0, 16'h0000));
        send_word(dma_word(FUNC_REQ_LINE, 4'd0, 8'h01, 8'h00, 2'd0, 16'h0000));
        // Address wraps into the bank, count underflows and masks the channel
        send_word(dma_word(FUNC_TICK, 4'd0, 8'h00, 8'h00, 2'd0, 16'hFFFF));
        send_word(dma_word(FUNC_REG_RD, REG_STATUS, 8'h00, 8'h00, 2'd0, 16'h0000));
        send_word(dma_word(FUNC_REG_RD, REG_TEMP, 8'h00, 8'h00, 2'd0, 16'h0000));
        send_word(dma_word(FUNC_BANK_RD, 4'd0, 8'h00, 8'h00, 2'd0, 16'h0000));
    endtask

    // Decrement, autoinit, illegal kind, master clear and verify
    task automatic test_transfer_modes();
        send_word(dma_word(FUNC_REG_WR, REG_MODE, 8'h3F, 8'h00, 2'd0, 16'h0000));
        send_word(dma_word(FUNC_REG_WR, REG_CLR_MASK, 8'h00, 8'h00, 2'd0, 16'h0000));
        send_word(dma_word(FUNC_REG_WR, REG_REQUEST, 8'h07, 8'h00, 2'd0, 16'h0000));
        send_word(dma_word(FUNC_TICK, 4'd0, 8'h00, 8'h00, 2'd0, 16'hA5A5));
        send_word(dma_word(FUNC_REG_WR, REG_MASTER, 8'h00, 8'h00, 2'd0, 16'h0000));
        send_word(dma_word(FUNC_REG_WR, REG_MODE, 8'h01, 8'h00, 2'd0, 16'h0000));
        send_word(dma_word(FUNC_REG_WR, REG_LOAD_MASK, 8'hFD, 8'h00, 2'd0, 16'h0000));
        send_word(dma_word(FUNC_REQ_LINE, 4'd0, 8'hFF, 8'h00, 2'd1, 16'h0000));
        send_word(dma_word(FUNC_TICK, 4'd0, 8'h00, 8'h00, 2'd0, 16'h0000));
        send_word(dma_word(FUNC_CMASK_RD, 4'd0, 8'h00, 8'h00, 2'd1, 16'h0000));
    endtask

    // Program one channel completely, start it and tick it through terminal count
    task automatic run_channel_program();
        logic [1:0]  ch;
        logic [7:0]  mode;
        logic [15:0] start;
        logic [15:0] count;
        int unsigned ticks;
        ch = 2'($urandom);
        mode = {6'($urandom), ch};
        case ($urandom_range(0, 3))
            0: start = 16'hFFFF - 16'($urandom_range(0, 3));
            1: start = 16'($urandom_range(0, 3));
            default: start = 16'($urandom);
        endcase
        if ($urandom_range(0, 9) == 0) count = 16'($urandom_range(10, 40));
        else count = 16'($urandom_range(0, 9));
        send_word(dma_word(FUNC_REG_WR, REG_CLR_FF, 8'($urandom), 8'h00, ch, 16'($urandom)));
        send_word(dma_word(FUNC_REG_WR, REG_MODE, mode, 8'h00, ch, 16'($urandom)));
        send_word(dma_word(FUNC_REG_WR, {1'b0, ch, 1'b0}, start[7:0], 8'h00, ch, 16'h0));
        send_word(dma_word(FUNC_REG_WR, {1'b0, ch, 1'b0}, start[15:8], 8'h00, ch, 16'h0));
        send_word(dma_word(FUNC_REG_WR, {1'b0, ch, 1'b1}, count[7:0], 8'h00, ch, 16'h0));
        send_word(dma_word(FUNC_REG_WR, {1'b0, ch, 1'b1}, count[15:8], 8'h00, ch, 16'h0));
        send_word(dma_word(FUNC_BANK_WR, 4'($urandom), 8'($urandom),
                           ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'hFF, ch, 16'h0));
        send_word(dma_word(FUNC_CMASK_WR, 4'($urandom), 8'($urandom),
                           ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'hFF, ch, 16'h0));
        send_word(dma_word(FUNC_REG_WR, REG_SMASK, {6'($urandom) & 6'b111001, ch},
                           8'h00, ch, 16'h0));
        if ($urandom_range(0, 1) == 0) begin
            send_word(dma_word(FUNC_REQ_LINE, 4'($urandom), 8'($urandom) | 8'h01,
                               8'($urandom), ch, 16'h0));
        end else begin
            send_word(dma_word(FUNC_REG_WR, REG_REQUEST, {6'($urandom) | 6'b000001, ch},
                               8'h00, ch, 16'h0));
        end
        ticks = count + $urandom_range(1, 3);
        repeat (ticks) begin
            if ($urandom_range(0, 5) == 0) begin
                send_word(dma_word(FUNC_REG_RD + 3'(2 * $urandom_range(0, 1) * 2),
                                   4'($urandom), 8'h00, 8'h00, 2'($urandom), 16'h0));
            end
            send_word(dma_word(FUNC_TICK, 4'($urandom), 8'($urandom), 8'($urandom),
                               2'($urandom), 16'($urandom)));
        end
    endtask

    // Configuration sweep with random programs and noise in each phase
    task automatic test_random_traffic();
        logic [31:0] masks [5];
        int unsigned phase;
        int unsigned target;
        masks[0] = 32'hFFFF_FFFF;
        masks[1] = 32'h0000_0000;
        masks[2] = ADDR_MASK_RESET;
        masks[3] = 32'($urandom);
        masks[4] = 32'($urandom);
        for (phase = 0; phase < 5; phase++) begin
            write_cfg(CFG_WORD_MODE, {31'($urandom), ~phase[0]});
            write_cfg(CFG_ADDR_MASK, masks[phase]);
            no_idle = (phase == 2);
            target = words_sent + 270;
            while (words_sent < target) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 5)) send_word(random_word());
                end else begin
                    run_channel_program();
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Result side: random stalls
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            m_ready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            ready_gap = idle_gap();
            if (ready_gap == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                ready_hold = ready_gap - 1;
            end
        end
    end

    // Compare each returned word with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (dma_results_due.size() == 0) begin
                report_error($sformatf("result word %h with nothing expected", m_data));
            end else begin
                oldest_due = dma_results_due.pop_front();
                if (m_data.read_data !== oldest_due.read_data)
                    report_error($sformatf("read_data %h, expected %h",
                                           m_data.read_data, oldest_due.read_data));
                if (m_data.xfer_valid !== oldest_due.xfer_valid)
                    report_error($sformatf("xfer_valid %b, expected %b",
                                           m_data.xfer_valid, oldest_due.xfer_valid));
                if (m_data.xfer_channel !== oldest_due.xfer_channel)
                    report_error($sformatf("xfer_channel %0d, expected %0d",
                                           m_data.xfer_channel, oldest_due.xfer_channel));
                if (m_data.xfer_kind !== oldest_due.xfer_kind)
                    report_error($sformatf("xfer_kind %0d, expected %0d",
                                           m_data.xfer_kind, oldest_due.xfer_kind));
                if (m_data.mem_address !== oldest_due.mem_address)
                    report_error($sformatf("mem_address %h, expected %h",
                                           m_data.mem_address, oldest_due.mem_address));
                if (m_data.tc_line_event !== oldest_due.tc_line_event)
                    report_error($sformatf("tc_line_event %0d, expected %0d",
                                           m_data.tc_line_event, oldest_due.tc_line_event));
            end
        end
    end

    initial begin
        // Predicted state after reset
        word_mode = 1'b0;
        mem_mask = ADDR_MASK_RESET;
        flip_hi = 1'b0;
        req_bits = '0;
        mask_bits = 4'hF;
        tc_bits = '0;
        temp_reg = '0;
        for (int i = 0; i < 4; i++) begin
            base_addr[i] = '0;
            cur_addr[i] = '0;
            base_cnt[i] = '0;
            cur_cnt[i] = '0;
            chan_mode[i] = '0;
            bank[i] = '0;
            carry_mask[i] = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_access();
        test_transfer_modes();
        test_random_traffic();

        // Drain, then allow for the pipeline depth
        s_valid <= 1'b0;
        while (dma_results_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
